>>> sv/rso_pkg.sv
package rso_pkg;

	typedef enum logic [1:0] {
		CMD_INTERSECT = 2'd0,
		CMD_UNION     = 2'd1,
		CMD_SUBTRACT  = 2'd2
	} rso_cmd_t;

	typedef struct packed {
		logic a_empty;
		logic b_empty;
	} rso_flags_t;

endpackage

>>> sv/rso_if.sv
interface rso_req_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   command;
	logic signed [COORD_BITS-1:0] a_left;
	logic signed [COORD_BITS-1:0] a_top;
	logic signed [COORD_BITS-1:0] a_right;
	logic signed [COORD_BITS-1:0] a_bottom;
	logic signed [COORD_BITS-1:0] b_left;
	logic signed [COORD_BITS-1:0] b_top;
	logic signed [COORD_BITS-1:0] b_right;
	logic signed [COORD_BITS-1:0] b_bottom;

	modport source (
		output valid, command, a_left, a_top, a_right, a_bottom,
		       b_left, b_top, b_right, b_bottom,
		input  ready
	);
	modport sink (
		input  valid, command, a_left, a_top, a_right, a_bottom,
		       b_left, b_top, b_right, b_bottom,
		output ready
	);
endinterface

interface rso_rsp_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] out_left;
	logic signed [COORD_BITS-1:0] out_top;
	logic signed [COORD_BITS-1:0] out_right;
	logic signed [COORD_BITS-1:0] out_bottom;
	logic                         nonempty;

	modport source (
		output valid, out_left, out_top, out_right, out_bottom, nonempty,
		input  ready
	);
	modport sink (
		input  valid, out_left, out_top, out_right, out_bottom, nonempty,
		output ready
	);
endinterface

>>> sv/rso_front.sv
module rso_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   command,
	input  logic signed [COORD_BITS-1:0] a_l,
	input  logic signed [COORD_BITS-1:0] a_t,
	input  logic signed [COORD_BITS-1:0] a_r,
	input  logic signed [COORD_BITS-1:0] a_b,
	input  logic signed [COORD_BITS-1:0] b_l,
	input  logic signed [COORD_BITS-1:0] b_t,
	input  logic signed [COORD_BITS-1:0] b_r,
	input  logic signed [COORD_BITS-1:0] b_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   command_s1,
	output rso_pkg::rso_flags_t          flags_s1,
	output logic signed [COORD_BITS-1:0] a_s1 [4],
	output logic signed [COORD_BITS-1:0] b_s1 [4],
	output logic signed [COORD_BITS-1:0] ix_s1 [4],
	output logic signed [COORD_BITS-1:0] un_s1 [4]
);
	logic                valid_s1;
	rso_pkg::rso_flags_t flags;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_comb begin
		flags.a_empty = (a_l >= a_r) || (a_t >= a_b);
		flags.b_empty = (b_l >= b_r) || (b_t >= b_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// order in each array: left, top, right, bottom
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			flags_s1   <= flags;
			a_s1[0] <= a_l;
			a_s1[1] <= a_t;
			a_s1[2] <= a_r;
			a_s1[3] <= a_b;
			b_s1[0] <= b_l;
			b_s1[1] <= b_t;
			b_s1[2] <= b_r;
			b_s1[3] <= b_b;
			ix_s1[0] <= (a_l > b_l) ? a_l : b_l;
			ix_s1[1] <= (a_t > b_t) ? a_t : b_t;
			ix_s1[2] <= (a_r < b_r) ? a_r : b_r;
			ix_s1[3] <= (a_b < b_b) ? a_b : b_b;
			un_s1[0] <= (a_l < b_l) ? a_l : b_l;
			un_s1[1] <= (a_t < b_t) ? a_t : b_t;
			un_s1[2] <= (a_r > b_r) ? a_r : b_r;
			un_s1[3] <= (a_b > b_b) ? a_b : b_b;
		end
	end
endmodule

>>> sv/rso_select.sv
module rso_select #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   command_s1,
	input  rso_pkg::rso_flags_t          flags_s1,
	input  logic signed [COORD_BITS-1:0] a_s1 [4],
	input  logic signed [COORD_BITS-1:0] b_s1 [4],
	input  logic signed [COORD_BITS-1:0] ix_s1 [4],
	input  logic signed [COORD_BITS-1:0] un_s1 [4],
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] res_s2 [4],
	output logic                         nonempty_s2
);
	logic                         valid_s2;
	logic                         ix_empty;
	logic                         ov_ok;
	logic                         full_h;
	logic                         full_w;
	logic signed [COORD_BITS-1:0] res [4];
	logic                         ok;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	always_comb begin
		ix_empty = (ix_s1[0] >= ix_s1[2]) || (ix_s1[1] >= ix_s1[3]);
		ov_ok    = !flags_s1.a_empty && !flags_s1.b_empty && !ix_empty;
		full_h   = (ix_s1[1] == a_s1[1]) && (ix_s1[3] == a_s1[3]);
		full_w   = (ix_s1[0] == a_s1[0]) && (ix_s1[2] == a_s1[2]);
		for (int i = 0; i < 4; i++) begin
			res[i] = '0;
		end
		ok = 1'b0;
		unique case (rso_pkg::rso_cmd_t'(command_s1))
			rso_pkg::CMD_INTERSECT: begin
				if (ov_ok) begin
					res = ix_s1;
					ok  = 1'b1;
				end
			end
			rso_pkg::CMD_UNION: begin
				if (!flags_s1.a_empty && !flags_s1.b_empty) begin
					res = un_s1;
					ok  = 1'b1;
				end else if (!flags_s1.b_empty) begin
					res = b_s1;
					ok  = 1'b1;
				end else if (!flags_s1.a_empty) begin
					res = a_s1;
					ok  = 1'b1;
				end
			end
			rso_pkg::CMD_SUBTRACT: begin
				if (!flags_s1.a_empty && !(ov_ok && full_h && full_w)) begin
					res = a_s1;
					ok  = 1'b1;
					if (ov_ok) begin
						if (full_h) begin
							if (ix_s1[0] == a_s1[0]) res[0] = ix_s1[2];
							else if (ix_s1[2] == a_s1[2]) res[2] = ix_s1[0];
						end else if (full_w) begin
							if (ix_s1[1] == a_s1[1]) res[1] = ix_s1[3];
							else if (ix_s1[3] == a_s1[3]) res[3] = ix_s1[1];
						end
					end
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_s2      <= res;
			nonempty_s2 <= ok;
		end
	end
endmodule

>>> sv/rectangle_set_operations.sv
// channel | dir | payload                                   | handshake
// req     | in  | command, a_left..a_bottom, b_left..b_bottom | valid/ready
// rsp     | out | out_left..out_bottom, nonempty             | valid/ready
//
// Three register stages: compares/min/max, case select, output register.
// One transaction per cycle sustained while rsp does not stall.
// arst_n clears the stage valid bits only.
// A stall on rsp holds every full stage while empty stages still fill; ready ripples back combinationally.
module rectangle_set_operations #(
	parameter int COORD_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	rso_req_if.sink  req,
	rso_rsp_if.source rsp
);
	logic                         v1, r1, v2, r2;
	logic [1:0]                   command_s1;
	rso_pkg::rso_flags_t          flags_s1;
	logic signed [COORD_BITS-1:0] a_s1 [4];
	logic signed [COORD_BITS-1:0] b_s1 [4];
	logic signed [COORD_BITS-1:0] ix_s1 [4];
	logic signed [COORD_BITS-1:0] un_s1 [4];
	logic signed [COORD_BITS-1:0] res_s2 [4];
	logic                         nonempty_s2;
	logic                         valid_s3;
	logic signed [COORD_BITS-1:0] res_s3 [4];
	logic                         nonempty_s3;

	rso_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.command    (req.command),
		.a_l        (req.a_left),
		.a_t        (req.a_top),
		.a_r        (req.a_right),
		.a_b        (req.a_bottom),
		.b_l        (req.b_left),
		.b_t        (req.b_top),
		.b_r        (req.b_right),
		.b_b        (req.b_bottom),
		.out_valid  (v1),
		.out_ready  (r1),
		.command_s1 (command_s1),
		.flags_s1   (flags_s1),
		.a_s1       (a_s1),
		.b_s1       (b_s1),
		.ix_s1      (ix_s1),
		.un_s1      (un_s1)
	);

	rso_select #(.COORD_BITS(COORD_BITS)) u_select (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v1),
		.in_ready    (r1),
		.command_s1  (command_s1),
		.flags_s1    (flags_s1),
		.a_s1        (a_s1),
		.b_s1        (b_s1),
		.ix_s1       (ix_s1),
		.un_s1       (un_s1),
		.out_valid   (v2),
		.out_ready   (r2),
		.res_s2      (res_s2),
		.nonempty_s2 (nonempty_s2)
	);

	assign r2 = !valid_s3 || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (r2) begin
			valid_s3 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (r2 && v2) begin
			res_s3      <= res_s2;
			nonempty_s3 <= nonempty_s2;
		end
	end

	assign rsp.valid      = valid_s3;
	assign rsp.out_left   = res_s3[0];
	assign rsp.out_top    = res_s3[1];
	assign rsp.out_right  = res_s3[2];
	assign rsp.out_bottom = res_s3[3];
	assign rsp.nonempty   = nonempty_s3;
endmodule

>>> sv/rso_checker.sv
module rso_checker #(
	parameter int COORD_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic signed [COORD_BITS-1:0] rsp_left,
	input logic signed [COORD_BITS-1:0] rsp_top,
	input logic signed [COORD_BITS-1:0] rsp_right,
	input logic signed [COORD_BITS-1:0] rsp_bottom,
	input logic                         rsp_nonempty
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left) && $stable(rsp_top)
			&& $stable(rsp_right) && $stable(rsp_bottom) && $stable(rsp_nonempty))
		else $error("rsp transaction changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_nonempty |-> rsp_left == '0 && rsp_top == '0
			&& rsp_right == '0 && rsp_bottom == '0)
		else $error("empty result is not the zero rectangle");

	a_nonempty_box: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_nonempty |-> rsp_left < rsp_right && rsp_top < rsp_bottom)
		else $error("result flagged nonempty is empty");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req not ready while output stage is free");
endmodule

bind rectangle_set_operations rso_checker #(.COORD_BITS(COORD_BITS)) u_rso_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_left     (rsp.out_left),
	.rsp_top      (rsp.out_top),
	.rsp_right    (rsp.out_right),
	.rsp_bottom   (rsp.out_bottom),
	.rsp_nonempty (rsp.nonempty)
);
